// File: src/olt_pkg.sv
// Package for the ordered list table: sizes, request and status codes,
// the per-cell control bundle and the prefix-OR helper.
// No dependencies.
package olt_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LEN_W       = 9;
    localparam int POS_W       = 8;
    localparam int ITEM_W      = 32;
    localparam int REQ_W       = 3;
    localparam int STAT_W      = 2;
    localparam int SCAN_STEPS  = $clog2(CAPACITY);

    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_VAL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_POS = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // Control for one cell in one cycle. Load wins over shifting.
    typedef struct packed {
        logic load;     // take the new value
        logic shift_up; // take the value of the cell below
        logic shift_dn; // take the value of the cell above
        logic cmp_en;   // register the comparison against the search value
    } cell_ctrl_t;

    // Bit i of the result is set when any bit at or below i is set.
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] vec);
        logic [CAPACITY-1:0] acc;
        acc = vec;
        for (int s = 0; s < SCAN_STEPS; s++) begin
            acc = acc | (acc << (1 << s));
        end
        return acc;
    endfunction

endpackage

// File: src/olt_cell.sv
// One storage cell of the ordered list: a value register that loads, takes
// a neighbour's value, and registers an equality match against a search value.
// Depends on olt_pkg.
module olt_cell (
    input  logic                aclk,
    input  olt_pkg::cell_ctrl_t ctrl,
    input  olt_pkg::value_t     new_value,
    input  olt_pkg::value_t     below_value,
    input  olt_pkg::value_t     above_value,
    input  olt_pkg::value_t     search_value,
    output olt_pkg::value_t     value_out,
    output logic                match_out
);

    olt_pkg::value_t value_reg;
    logic            match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            value_reg <= new_value;
        end else if (ctrl.shift_up) begin
            value_reg <= below_value;
        end else if (ctrl.shift_dn) begin
            value_reg <= above_value;
        end
        if (ctrl.cmp_en) begin
            match_reg <= (value_reg == search_value);
        end
    end

    assign value_out = value_reg;
    assign match_out = match_reg;

endmodule

// File: src/ordered_list_table_unit.sv
// Ordered list table: a row of cells holding the list, with one control FSM.
// The request is registered on acceptance; the result is registered when the execute state
// commits. No new request is taken until then (compare on acceptance, then shift in the row).
// The execute cycle waits while an earlier result has not been taken.
// Reset (aresetn low, synchronous) empties the list and the output register;
// the cell contents are not cleared, since only entries below the length are read.
module ordered_list_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // position [7:0], item_value [39:8]
    input  logic [2:0]  s_tuser,  // req_type [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // read_value [31:0], list_length [40:32], zero pad
    output logic [1:0]  m_tuser   // status [1:0]
);

    localparam int N = olt_pkg::CAPACITY;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t                         state_reg, state_next;
    logic [olt_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [olt_pkg::REQ_W-1:0]      req_reg;
    logic [olt_pkg::POS_W-1:0]      pos_reg;
    olt_pkg::value_t                val_reg;
    logic                           m_valid_reg;
    logic [olt_pkg::STAT_W-1:0]     m_status_reg, status_next;
    logic [olt_pkg::ITEM_W-1:0]     m_rd_reg, rd_next;
    logic [olt_pkg::LEN_W-1:0]      m_len_reg;

    olt_pkg::cell_ctrl_t            ctrl [N];
    olt_pkg::value_t                cell_val [N];
    logic [N-1:0]                   match_vec;
    logic [N-1:0]                   match_live;
    logic [N-1:0]                   found_vec;
    olt_pkg::value_t                search_value;

    logic                           accept;
    logic                           commit;
    logic                           do_ins;
    logic                           do_del_pos;
    logic                           do_del_val;
    logic [olt_pkg::CNT_W-1:0]      pos_ext;
    logic [olt_pkg::CNT_W-1:0]      ins_at;
    logic                           is_full;
    olt_pkg::value_t                rd_value;

    assign accept       = s_tvalid && s_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign search_value = s_tdata[8 +: olt_pkg::VALUE_WIDTH];
    assign pos_ext      = olt_pkg::CNT_W'(pos_reg);
    assign is_full      = (count_reg >= olt_pkg::CNT_W'(N));
    // The result register is free when empty or being drained this cycle.
    assign commit       = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    // Only entries below the length take part in a value search.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            match_live[i] = match_vec[i] && (olt_pkg::CNT_W'(i) < count_reg);
        end
    end

    assign found_vec = olt_pkg::prefix_or(match_live);

    always_comb begin
        rd_value = '0;
        for (int i = 0; i < N; i++) begin
            rd_value = rd_value | ((olt_pkg::CNT_W'(i) == pos_ext) ? cell_val[i] : '0);
        end
    end

    always_comb begin
        status_next = olt_pkg::STAT_OK;
        rd_next     = '0;
        do_ins      = 1'b0;
        do_del_pos  = 1'b0;
        do_del_val  = 1'b0;
        ins_at      = count_reg;
        count_next  = count_reg;
        case (req_reg)
            olt_pkg::REQ_APPEND: begin
                if (is_full) begin
                    status_next = olt_pkg::STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            olt_pkg::REQ_INSERT: begin
                ins_at = pos_ext;
                if (pos_ext > count_reg) begin
                    status_next = olt_pkg::STAT_BADPOS;
                end else if (is_full) begin
                    status_next = olt_pkg::STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            olt_pkg::REQ_READ: begin
                if (pos_ext >= count_reg) begin
                    status_next = olt_pkg::STAT_BADPOS;
                end else begin
                    rd_next = olt_pkg::ITEM_W'(rd_value);
                end
            end
            olt_pkg::REQ_DEL_VAL: begin
                if (!found_vec[N-1]) begin
                    status_next = olt_pkg::STAT_NOTFOUND;
                end else begin
                    do_del_val = 1'b1;
                end
            end
            olt_pkg::REQ_DEL_POS: begin
                if (pos_ext >= count_reg) begin
                    status_next = olt_pkg::STAT_BADPOS;
                end else begin
                    do_del_pos = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_ins) begin
            count_next = count_reg + 1'b1;
        end else if (do_del_pos || do_del_val) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Insertion moves everything from the slot onwards up by one; deletion pulls
    // everything from the removed slot onwards down by one.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            ctrl[i].cmp_en   = accept;
            ctrl[i].load     = commit && do_ins && (olt_pkg::CNT_W'(i) == ins_at);
            ctrl[i].shift_up = commit && do_ins && (olt_pkg::CNT_W'(i) > ins_at);
            ctrl[i].shift_dn = commit && ((do_del_pos && (olt_pkg::CNT_W'(i) >= pos_ext))
                                          || (do_del_val && found_vec[i]));
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        olt_pkg::value_t below_value;
        olt_pkg::value_t above_value;
        if (g == 0) begin : g_first
            assign below_value = '0;
        end else begin : g_mid_lo
            assign below_value = cell_val[g-1];
        end
        if (g == N - 1) begin : g_last
            assign above_value = '0;
        end else begin : g_mid_hi
            assign above_value = cell_val[g+1];
        end
        olt_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl[g]),
            .new_value    (val_reg),
            .below_value  (below_value),
            .above_value  (above_value),
            .search_value (search_value),
            .value_out    (cell_val[g]),
            .match_out    (match_vec[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                req_reg <= s_tuser;
                pos_reg <= s_tdata[7:0];
                val_reg <= search_value;
            end
            if (commit) begin
                count_reg    <= count_next;
                m_valid_reg  <= 1'b1;
                m_status_reg <= status_next;
                m_rd_reg     <= rd_next;
                m_len_reg    <= olt_pkg::LEN_W'(count_next);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_len_reg, m_rd_reg};

endmodule
